// ===== rtl/tssgd_pkg.sv =====
package tssgd_pkg;

  // Number of LEDs a gesture sweep walks through.
  localparam int unsigned SWEEP_LEDS = 3;

  // Zone codes of one scan.
  typedef logic [1:0] zone_t;
  localparam zone_t ZONE_NONE   = 2'd0;
  localparam zone_t ZONE_FIRST  = 2'd1;
  localparam zone_t ZONE_BOTH   = 2'd2;
  localparam zone_t ZONE_SECOND = 2'd3;

  // Sweep pattern codes.
  typedef enum logic [2:0] {
    PAT_OFF = 3'd0,
    PAT_L2R = 3'd1,
    PAT_R2L = 3'd2,
    PAT_B2T = 3'd3,
    PAT_T2B = 3'd4
  } pattern_e;

  // Gesture event codes.
  typedef enum logic [1:0] {
    GEST_NONE = 2'd0,
    GEST_FWD  = 2'd1,
    GEST_BWD  = 2'd2
  } gesture_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LED_ON     = 2'd1,
    CFG_SWEEP_MODE = 2'd2,
    CFG_X_AXIS     = 2'd3
  } cfg_idx_e;

  // Configuration reset values.
  localparam logic [7:0] DEBOUNCE_RESET   = 8'd3;
  localparam logic [5:0] LED_ON_RESET     = 6'd10;
  localparam logic       SWEEP_MODE_RESET = 1'b1;
  localparam logic       X_AXIS_RESET     = 1'b1;

  // One result word.
  typedef struct packed {
    logic     led_left;
    logic     led_center;
    logic     led_right;
    logic     led_top;
    logic     led_bottom;
    zone_t    zone_seen;
    gesture_e gesture_event;
  } result_t;

endpackage

// ===== rtl/tssgd_scan_if.sv =====
// One sensor scan word.
interface tssgd_scan_if;
  logic valid;
  logic ready;
  logic first_active;
  logic second_active;

  modport source (output valid, output first_active, output second_active, input ready);
  modport sink (input valid, input first_active, input second_active, output ready);
endinterface

// ===== rtl/tssgd_result_if.sv =====
// One result word: LED states, zone and gesture event.
interface tssgd_result_if;
  logic       valid;
  logic       ready;
  logic       led_left;
  logic       led_center;
  logic       led_right;
  logic       led_top;
  logic       led_bottom;
  logic [1:0] zone_seen;
  logic [1:0] gesture_event;

  modport source (output valid, output led_left, output led_center, output led_right,
                  output led_top, output led_bottom, output zone_seen,
                  output gesture_event, input ready);
  modport sink (input valid, input led_left, input led_center, input led_right,
                input led_top, input led_bottom, input zone_seen,
                input gesture_event, output ready);
endinterface

// ===== rtl/two_sensor_swipe_gesture_detector_core.sv =====
// Result words are registered in the output register, or the skid entry on a stall.
// Throughput: one scan word per cycle while the skid entry is empty; the tracker
// and sweep update is one combinational step between the tracker state registers
// and the output register. A skid entry behind it takes one more word when the sink
// stalls; the scan side resumes in the cycle after the sink takes a word again.
// Reset (rst_ni, asynchronous, active low) clears the trackers, the sweep and the
// output buffer and loads the configuration registers with their defaults.
module two_sensor_swipe_gesture_detector_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  tssgd_scan_if.sink           scan_i,
  tssgd_result_if.source       result_o
);

  // Configuration registers.
  logic [7:0] debounce_q;
  logic [5:0] led_on_q;
  logic       sweep_mode_q;
  logic       x_axis_q;

  // Tracker and sweep state.
  tssgd_pkg::zone_t    present_zone_q, present_zone_d;
  tssgd_pkg::zone_t    accepted_zone_q, accepted_zone_d;
  logic                fwd_track_q, fwd_track_d;
  logic                bwd_track_q, bwd_track_d;
  logic [7:0]          fwd_cnt_q, fwd_cnt_d;
  logic [7:0]          bwd_cnt_q, bwd_cnt_d;
  tssgd_pkg::pattern_e pattern_q, pattern_d;
  logic [7:0]          tick_q, tick_d;

  // Output buffer.
  tssgd_pkg::result_t out_q, skid_q, res_d;
  logic               out_valid_q, skid_valid_q;

  logic accept;
  logic pop;

  assign scan_i.ready = !skid_valid_q;
  assign accept       = scan_i.valid && scan_i.ready;
  assign pop          = out_valid_q && result_o.ready;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= tssgd_pkg::DEBOUNCE_RESET;
      led_on_q     <= tssgd_pkg::LED_ON_RESET;
      sweep_mode_q <= tssgd_pkg::SWEEP_MODE_RESET;
      x_axis_q     <= tssgd_pkg::X_AXIS_RESET;
    end else if (cfg_we_i) begin
      case (tssgd_pkg::cfg_idx_e'(cfg_idx_i))
        tssgd_pkg::CFG_DEBOUNCE:   debounce_q   <= cfg_wdata_i;
        tssgd_pkg::CFG_LED_ON:     led_on_q     <= cfg_wdata_i[5:0];
        tssgd_pkg::CFG_SWEEP_MODE: sweep_mode_q <= cfg_wdata_i[0];
        tssgd_pkg::CFG_X_AXIS:     x_axis_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // One scan step: zone, both trackers, gesture detection and LED sweep.
  always_comb begin
    tssgd_pkg::zone_t    zone;
    tssgd_pkg::gesture_e gest;
    logic                cond;
    logic [5:0]          per;
    logic [7:0]          per1, per2, per3;
    logic                slot0, slot1, slot2;
    logic                l, c, r, t, b;

    present_zone_d  = present_zone_q;
    accepted_zone_d = accepted_zone_q;
    fwd_track_d     = fwd_track_q;
    bwd_track_d     = bwd_track_q;
    fwd_cnt_d       = fwd_cnt_q;
    bwd_cnt_d       = bwd_cnt_q;
    pattern_d       = pattern_q;
    tick_d          = tick_q;
    gest            = tssgd_pkg::GEST_NONE;
    cond            = 1'b0;
    l = 1'b0; c = 1'b0; r = 1'b0; t = 1'b0; b = 1'b0;

    case ({scan_i.first_active, scan_i.second_active})
      2'b10:   zone = tssgd_pkg::ZONE_FIRST;
      2'b01:   zone = tssgd_pkg::ZONE_SECOND;
      2'b11:   zone = tssgd_pkg::ZONE_BOTH;
      default: zone = tssgd_pkg::ZONE_NONE;
    endcase

    if (zone != tssgd_pkg::ZONE_NONE) begin
      // Forward tracker: zones must rise by one.
      if (present_zone_d != zone) begin
        fwd_cnt_d = debounce_q;
        bwd_cnt_d = debounce_q;
      end
      present_zone_d = zone;
      if (fwd_track_d && accepted_zone_d != present_zone_d &&
          {1'b0, present_zone_d} != {1'b0, accepted_zone_d} + 3'd1) begin
        fwd_track_d = 1'b0;
      end
      cond = (zone == tssgd_pkg::ZONE_FIRST) ? (accepted_zone_d == tssgd_pkg::ZONE_NONE)
                                             : fwd_track_d;
      if (cond) begin
        if (fwd_cnt_d != 8'd0) fwd_cnt_d = fwd_cnt_d - 8'd1;
      end else begin
        fwd_cnt_d = debounce_q;
      end
      if (fwd_cnt_d == 8'd0) begin
        accepted_zone_d = zone;
        if (zone == tssgd_pkg::ZONE_FIRST) fwd_track_d = 1'b1;
      end

      // Backward tracker: zones must fall by one.
      if (bwd_track_d && accepted_zone_d != present_zone_d &&
          {1'b0, accepted_zone_d} != {1'b0, present_zone_d} + 3'd1) begin
        bwd_track_d = 1'b0;
      end
      cond = (zone == tssgd_pkg::ZONE_SECOND) ? (accepted_zone_d == tssgd_pkg::ZONE_NONE)
                                              : bwd_track_d;
      if (cond) begin
        if (bwd_cnt_d != 8'd0) bwd_cnt_d = bwd_cnt_d - 8'd1;
      end else begin
        bwd_cnt_d = debounce_q;
      end
      if (bwd_cnt_d == 8'd0) begin
        accepted_zone_d = zone;
        if (zone == tssgd_pkg::ZONE_SECOND) bwd_track_d = 1'b1;
      end
    end else begin
      // Release: report a completed sweep and rearm both trackers.
      if (fwd_track_q && accepted_zone_q == tssgd_pkg::ZONE_SECOND) begin
        gest      = tssgd_pkg::GEST_FWD;
        pattern_d = x_axis_q ? tssgd_pkg::PAT_L2R : tssgd_pkg::PAT_B2T;
        tick_d    = 8'd0;
      end
      if (bwd_track_q && accepted_zone_q == tssgd_pkg::ZONE_FIRST) begin
        gest      = tssgd_pkg::GEST_BWD;
        pattern_d = x_axis_q ? tssgd_pkg::PAT_R2L : tssgd_pkg::PAT_T2B;
        tick_d    = 8'd0;
      end
      accepted_zone_d = tssgd_pkg::ZONE_NONE;
      present_zone_d  = tssgd_pkg::ZONE_NONE;
      fwd_track_d     = 1'b0;
      bwd_track_d     = 1'b0;
      fwd_cnt_d       = debounce_q;
      bwd_cnt_d       = debounce_q;
    end

    // Slot boundaries of the timed sweep; an LED time of zero counts as one.
    per   = (led_on_q == 6'd0) ? 6'd1 : led_on_q;
    per1  = {2'b00, per};
    per2  = {1'b0, per, 1'b0};
    per3  = 8'(per1 * tssgd_pkg::SWEEP_LEDS);
    slot0 = tick_d < per1;
    slot1 = !slot0 && (tick_d < per2);
    slot2 = (tick_d >= per2) && (tick_d < per3);

    if (sweep_mode_q) begin
      // Timed sweep in the direction of the last gesture.
      case (pattern_d)
        tssgd_pkg::PAT_L2R: begin l = slot0; c = slot1; r = slot2; end
        tssgd_pkg::PAT_R2L: begin r = slot0; c = slot1; l = slot2; end
        tssgd_pkg::PAT_B2T: begin b = slot0; c = slot1; t = slot2; end
        tssgd_pkg::PAT_T2B: begin t = slot0; c = slot1; b = slot2; end
        default: ;
      endcase
      if (pattern_d != tssgd_pkg::PAT_OFF) begin
        tick_d = tick_d + 8'd1;
        if (tick_d >= per3) pattern_d = tssgd_pkg::PAT_OFF;
      end
    end else begin
      // Position display of the current zone.
      case (zone)
        tssgd_pkg::ZONE_FIRST: begin
          if (x_axis_q) l = 1'b1; else b = 1'b1;
        end
        tssgd_pkg::ZONE_BOTH: c = 1'b1;
        tssgd_pkg::ZONE_SECOND: begin
          if (x_axis_q) r = 1'b1; else t = 1'b1;
        end
        default: ;
      endcase
    end

    res_d.led_left      = l;
    res_d.led_center    = c;
    res_d.led_right     = r;
    res_d.led_top       = t;
    res_d.led_bottom    = b;
    res_d.zone_seen     = zone;
    res_d.gesture_event = gest;
  end

  // Tracker and sweep state advance once per accepted scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_zone_q  <= tssgd_pkg::ZONE_NONE;
      accepted_zone_q <= tssgd_pkg::ZONE_NONE;
      fwd_track_q     <= 1'b0;
      bwd_track_q     <= 1'b0;
      fwd_cnt_q       <= tssgd_pkg::DEBOUNCE_RESET;
      bwd_cnt_q       <= tssgd_pkg::DEBOUNCE_RESET;
      pattern_q       <= tssgd_pkg::PAT_OFF;
      tick_q          <= 8'd0;
    end else if (accept) begin
      present_zone_q  <= present_zone_d;
      accepted_zone_q <= accepted_zone_d;
      fwd_track_q     <= fwd_track_d;
      bwd_track_q     <= bwd_track_d;
      fwd_cnt_q       <= fwd_cnt_d;
      bwd_cnt_q       <= bwd_cnt_d;
      pattern_q       <= pattern_d;
      tick_q          <= tick_d;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (accept) out_q <= res_d;
    end else if (accept) begin
      skid_q <= res_d;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.led_left      = out_q.led_left;
  assign result_o.led_center    = out_q.led_center;
  assign result_o.led_right     = out_q.led_right;
  assign result_o.led_top       = out_q.led_top;
  assign result_o.led_bottom    = out_q.led_bottom;
  assign result_o.zone_seen     = out_q.zone_seen;
  assign result_o.gesture_event = out_q.gesture_event;

endmodule

// ===== rtl/tssgd_checker.sv =====
module tssgd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       scan_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       led_left_i,
  input logic       led_center_i,
  input logic       led_right_i,
  input logic       led_top_i,
  input logic       led_bottom_i,
  input logic [1:0] zone_seen_i,
  input logic [1:0] gesture_event_i
);

  // A gesture is only reported on a scan where both sensors have released.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && gesture_event_i != tssgd_pkg::GEST_NONE
      |-> zone_seen_i == tssgd_pkg::ZONE_NONE)
    else $error("gesture reported while a sensor is active");

  // At most one LED is lit in either display mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $countones({led_left_i, led_center_i, led_right_i,
                                led_top_i, led_bottom_i}) <= 1)
    else $error("more than one LED lit");

  // The scan side only stalls while a result word is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !scan_ready_i |-> out_valid_i)
    else $error("scan side stalled with no result pending");

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(zone_seen_i) &&
      $stable(gesture_event_i))
    else $error("stalled result word changed");

endmodule

bind two_sensor_swipe_gesture_detector_core tssgd_checker u_tssgd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .scan_ready_i    (scan_i.ready),
  .out_valid_i     (result_o.valid),
  .out_ready_i     (result_o.ready),
  .led_left_i      (result_o.led_left),
  .led_center_i    (result_o.led_center),
  .led_right_i     (result_o.led_right),
  .led_top_i       (result_o.led_top),
  .led_bottom_i    (result_o.led_bottom),
  .zone_seen_i     (result_o.zone_seen),
  .gesture_event_i (result_o.gesture_event)
);
